// File: hdl/cpvp_pkg.sv
`timescale 1ns / 1ps
package cpvp_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_TARGET_CIRCLES = 3'd0;
    localparam logic [2:0] REG_TARGET_SPEED   = 3'd1;
    localparam logic [2:0] REG_POS_KP         = 3'd2;
    localparam logic [2:0] REG_POS_KI         = 3'd3;
    localparam logic [2:0] REG_POS_KD         = 3'd4;
    localparam logic [2:0] REG_VEL_KP         = 3'd5;
    localparam logic [2:0] REG_VEL_KI         = 3'd6;

    localparam logic [7:0]  TARGET_CIRCLES_RST = 8'd15;
    localparam logic [7:0]  TARGET_SPEED_RST   = 8'd40;

    // target in Q.8 is circles * 276889.6: integer part plus (circles*3)/5
    localparam logic [18:0] TGT_MUL   = 19'd276889;
    localparam logic [7:0]  RCP5      = 8'd205;      // 2^10 / 5, rounded up
    localparam logic [6:0]  SPD_SCALE = 7'd76;
    localparam logic [14:0] RCP76     = 15'd27595;   // 2^21 / 76, rounded up
    localparam logic signed [41:0] INTEG_LIM = 42'sd248320;
    localparam logic [15:0] RAW_NEG_TH = 16'hefff;

    typedef enum logic [2:0] {
        MS_KP  = 3'd0,
        MS_KI  = 3'd1,
        MS_KD  = 3'd2,
        MS_VKP = 3'd3,
        MS_VKI = 3'd4
    } t_msel;

    typedef struct packed {
        logic  load;
        logic  err;
        logic  mul_en;
        t_msel msel;
        logic  acc_en;
        logic  acc_clr;
        logic  quot;
        logic  scale;
        logic  verr;
        logic  drv;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic run;
        logic out_free;
    } t_stat;

endpackage

// File: hdl/cpvp_ctrl.sv
`timescale 1ns / 1ps
module cpvp_ctrl
    import cpvp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_stat i_stat,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_ERR  = 14'b00000000000010,
        S_M0   = 14'b00000000000100,
        S_M1   = 14'b00000000001000,
        S_M2   = 14'b00000000010000,
        S_M3   = 14'b00000000100000,
        S_QT   = 14'b00000001000000,
        S_DIV  = 14'b00000010000000,
        S_VE   = 14'b00000100000000,
        S_M4   = 14'b00001000000000,
        S_M5   = 14'b00010000000000,
        S_M6   = 14'b00100000000000,
        S_INC  = 14'b01000000000000,
        S_FIN  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.msel = MS_KP;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ERR;
                end
            end
            S_ERR: begin
                // skip the loops and hold their state while stopped
                if (i_stat.run) begin
                    o_cmd.err = 1'b1;
                    n_state   = S_M0;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_M0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_KP;
                n_state      = S_M1;
            end
            S_M1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.msel    = MS_KI;
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state       = S_M2;
            end
            S_M2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_KD;
                o_cmd.acc_en = 1'b1;
                n_state      = S_M3;
            end
            S_M3: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_QT;
            end
            S_QT: begin
                o_cmd.quot = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.scale = 1'b1;
                n_state     = S_VE;
            end
            S_VE: begin
                o_cmd.verr = 1'b1;
                n_state    = S_M4;
            end
            S_M4: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_VKP;
                n_state      = S_M5;
            end
            S_M5: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.msel    = MS_VKI;
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state       = S_M6;
            end
            S_M6: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_INC;
            end
            S_INC: begin
                o_cmd.drv = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // wait here while the previous result is still unread
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/cpvp_dp.sv
`timescale 1ns / 1ps
module cpvp_dp
    import cpvp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic [16:0] i_in_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [87:0] o_out_data
);

    logic [7:0]         r_tc, r_ts;
    logic signed [15:0] r_pkp, r_pki, r_pkd, r_vkp, r_vki;

    logic               r_run;
    logic signed [16:0] r_speed;
    logic [31:0]        r_pos;
    logic signed [39:0] r_perr;
    logic signed [18:0] r_integ;
    logic signed [40:0] r_diff;
    logic signed [56:0] r_prod;
    logic signed [58:0] r_acc;
    logic [14:0]        r_qmag;
    logic               r_qneg;
    logic [7:0]         r_smag;
    logic signed [17:0] r_sperr;
    logic signed [18:0] r_dv;
    logic signed [31:0] r_drive;

    logic               r_ovalid;
    logic signed [31:0] r_odrive;
    logic signed [16:0] r_ospeed;
    logic [31:0]        r_opos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc  <= TARGET_CIRCLES_RST;
            r_ts  <= TARGET_SPEED_RST;
            r_pkp <= '0;
            r_pki <= '0;
            r_pkd <= '0;
            r_vkp <= '0;
            r_vki <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_TARGET_CIRCLES: r_tc  <= i_cfg_wdata[7:0];
                REG_TARGET_SPEED:   r_ts  <= i_cfg_wdata[7:0];
                REG_POS_KP:         r_pkp <= i_cfg_wdata;
                REG_POS_KI:         r_pki <= i_cfg_wdata;
                REG_POS_KD:         r_pkd <= i_cfg_wdata;
                REG_VEL_KP:         r_vkp <= i_cfg_wdata;
                REG_VEL_KI:         r_vki <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // signed encoder delta
    logic [15:0]        raw;
    logic signed [16:0] speed_n;
    assign raw     = i_in_data[15:0];
    assign speed_n = (raw > RAW_NEG_TH) ? ($signed({1'b0, raw}) - 17'sh0ffff)
                                        : $signed({1'b0, raw});

    // position error and integral
    logic [26:0]        tgt_main, tgt;
    logic [9:0]         frac3;
    logic [17:0]        frac;
    logic signed [41:0] err_full, integ_full;
    logic signed [39:0] err_sat;
    logic signed [18:0] integ_n;
    logic signed [40:0] diff_n;

    assign tgt_main = {19'd0, r_tc} * {8'd0, TGT_MUL};
    assign frac3    = {2'b0, r_tc} + {1'b0, r_tc, 1'b0};
    assign frac     = {8'd0, frac3} * {10'd0, RCP5};
    assign tgt      = tgt_main + {19'd0, frac[17:10]};
    assign err_full = $signed({15'd0, tgt}) - $signed({{2{r_pos[31]}}, r_pos, 8'd0});

    always_comb begin
        if (err_full > $signed({3'b000, {39{1'b1}}})) begin
            err_sat = {1'b0, {39{1'b1}}};
        end else if (err_full < $signed({3'b111, 39'd0})) begin
            err_sat = {1'b1, 39'd0};
        end else begin
            err_sat = err_full[39:0];
        end
    end

    assign integ_full = {{2{err_sat[39]}}, err_sat} + {{23{r_integ[18]}}, r_integ};

    always_comb begin
        if (integ_full > INTEG_LIM) begin
            integ_n = 19'(INTEG_LIM);
        end else if (integ_full < -INTEG_LIM) begin
            integ_n = 19'(-INTEG_LIM);
        end else begin
            integ_n = integ_full[18:0];
        end
    end

    assign diff_n = {err_sat[39], err_sat} - {r_perr[39], r_perr};

    // shared multiplier
    logic signed [15:0] mul_a;
    logic signed [40:0] mul_b;
    logic signed [56:0] mul_p;

    always_comb begin
        unique case (i_cmd.msel)
            MS_KP: begin
                mul_a = r_pkp;
                mul_b = {r_perr[39], r_perr};
            end
            MS_KI: begin
                mul_a = r_pki;
                mul_b = {{22{r_integ[18]}}, r_integ};
            end
            MS_KD: begin
                mul_a = r_pkd;
                mul_b = r_diff;
            end
            MS_VKP: begin
                mul_a = r_vkp;
                mul_b = {{22{r_dv[18]}}, r_dv};
            end
            MS_VKI: begin
                mul_a = r_vki;
                mul_b = {{23{r_sperr[17]}}, r_sperr};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // position output: divide by 2^16 toward zero, then limit
    logic signed [42:0] q_n, lim;
    logic [14:0]        lim15;
    logic [29:0]        sc;

    assign q_n   = r_acc[58:16] + 43'(r_acc[58] && (|r_acc[15:0]));
    assign lim15 = {7'd0, r_ts} * {8'd0, SPD_SCALE};
    assign lim   = $signed({28'd0, lim15});
    assign sc    = {15'd0, r_qmag} * {15'd0, RCP76};

    // speed loop
    logic signed [17:0] setp, verr_n;
    logic signed [18:0] dv_n;
    logic signed [50:0] inc;
    logic signed [51:0] dsum;
    logic signed [31:0] drive_n;

    assign setp   = r_qneg ? -$signed({10'd0, r_smag}) : $signed({10'd0, r_smag});
    assign verr_n = setp - {r_speed[16], r_speed};
    assign dv_n   = {verr_n[17], verr_n} - {r_sperr[17], r_sperr};
    assign inc    = r_acc[58:8] + 51'(r_acc[58] && (|r_acc[7:0]));
    assign dsum   = {{20{r_drive[31]}}, r_drive} + {inc[50], inc};

    always_comb begin
        if (dsum > $signed({21'd0, {31{1'b1}}})) begin
            drive_n = {1'b0, {31{1'b1}}};
        end else if (dsum < $signed({{21{1'b1}}, 31'd0})) begin
            drive_n = {1'b1, 31'd0};
        end else begin
            drive_n = dsum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_perr  <= '0;
            r_integ <= '0;
            r_sperr <= '0;
            r_drive <= '0;
            r_run   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_run   <= i_in_data[16];
                r_speed <= speed_n;
                r_pos   <= r_pos + {{15{speed_n[16]}}, speed_n};
            end
            if (i_cmd.err) begin
                r_perr  <= err_sat;
                r_integ <= integ_n;
                r_diff  <= diff_n;
            end
            if (i_cmd.verr) begin
                r_sperr <= verr_n;
                r_dv    <= dv_n;
            end
            if (i_cmd.drv) begin
                r_drive <= drive_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.acc_en) begin
            r_acc <= (i_cmd.acc_clr ? 59'sd0 : r_acc) + {{2{r_prod[56]}}, r_prod};
        end
        if (i_cmd.quot) begin
            if (q_n > lim) begin
                r_qmag <= lim15;
                r_qneg <= 1'b0;
            end else if (q_n < -lim) begin
                r_qmag <= lim15;
                r_qneg <= 1'b1;
            end else begin
                r_qmag <= q_n[42] ? 15'(-q_n) : q_n[14:0];
                r_qneg <= q_n[42];
            end
        end
        if (i_cmd.scale) begin
            r_smag <= sc[28:21];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odrive <= r_run ? r_drive : 32'sd0;
            r_ospeed <= r_speed;
            r_opos   <= r_pos;
        end
    end

    assign o_stat.run      = r_run;
    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid     = r_ovalid;
    assign o_out_data      = {7'd0, r_opos, r_ospeed, r_odrive};

endmodule

// File: hdl/cascaded_position_velocity_pid.sv
`timescale 1ns / 1ps
// Cascaded position / speed controller, one result per control tick.
// Slave stream: one request per tick, tdata = {run, raw_count}; raw_count is
// the encoder counter read this tick, run = 0 forces drive to zero.
// Master stream: one result per request, tdata = {position, speed, drive}.
// Configuration: write enable, register index and 16-bit data; gains and
// targets take effect from the next request. Write only while idle.
// Sequence: a running request steps through error update, the position
// products, quotient limit, reciprocal scaling, speed error, the speed
// products, drive update and output load; a stopped request skips the
// loop steps and goes straight to the output load. The sequencer steps
// the shared 16 x 41 multiplier through five products and the fixed
// reciprocal scaling, one step a cycle; only the output load can wait.
// One request is processed at a time; s_axis_tready is high only while the
// sequencer is idle, and it returns idle as soon as the result is registered.
// A stalled receiver holds the result in the output register; a following
// request is still accepted and completes up to its final step, then waits.
// Reset (synchronous, active low) clears the position, loop state and drive,
// restores target_circles = 15 and target_speed = 40, and zeroes the gains.
module cascaded_position_velocity_pid
    import cpvp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] raw_count, [16] run, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // [31:0] drive, [48:32] speed, [80:49] position
);

    t_cmd  cmd;
    t_stat stat;

    cpvp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    cpvp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata[16:0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: hdl/cpvp_chk.sv
`timescale 1ns / 1ps
module cpvp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("outputs not idle after reset");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[48] |-> m_axis_tdata[48:44] == 5'h1f)
        else $error("speed out of range");

endmodule

bind cascaded_position_velocity_pid cpvp_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import cpvp_pkg::*;

    typedef struct packed {
        logic [15:0] raw_count;
        logic        run;
    } t_tick;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [16:0] speed;
        logic signed [31:0] position;
    } t_ctl_out;

    localparam longint ERR_HI = 64'sd549755813887;
    localparam longint ERR_LO = -64'sd549755813888;
    localparam longint INTEG_Q8 = 970 * 256;
    localparam int CYCLE_LIMIT = 900000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // [15:0] raw_count, [16] run
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;    // [31:0] drive, [48:32] speed, [80:49] position

    cascaded_position_velocity_pid dut (.*);

    // controller image
    logic [7:0]         circles_q, spd_lim_q;
    logic signed [15:0] gain_pkp, gain_pki, gain_pkd, gain_vkp, gain_vki;
    logic [31:0]        pos_acc;
    longint             prev_perr, integ, prev_verr, drive_acc;

    t_tick    tick_queue[$];
    t_ctl_out ctl_expected[$];
    int       errors;
    int       cycles;
    int       hold_off;
    bit       stim_done;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_ctl_out control_tick(t_tick t);
        t_ctl_out r;
        longint spd, pos, tgt, err, acc, q, lim, setp, verr, inc;
        spd = t.raw_count;
        if (t.raw_count > 16'hefff) spd = spd - 65535;
        pos_acc = pos_acc + spd[31:0];
        pos = longint'($signed(pos_acc));
        r.drive = 0;
        if (t.run) begin
            tgt = (longint'(circles_q) * 2768896) / 10;
            err = clip(tgt - pos * 256, ERR_LO, ERR_HI);
            integ = clip(integ + err, -INTEG_Q8, INTEG_Q8);
            acc = longint'(gain_pkp) * err + longint'(gain_pki) * integ
                + longint'(gain_pkd) * (err - prev_perr);
            prev_perr = err;
            q = acc / 65536;
            lim = longint'(spd_lim_q) * 76;
            q = clip(q, -lim, lim);
            setp = q / 76;
            verr = setp - spd;
            inc = (longint'(gain_vkp) * (verr - prev_verr) + longint'(gain_vki) * verr) / 256;
            prev_verr = verr;
            drive_acc = clip(drive_acc + inc, -64'sd2147483648, 64'sd2147483647);
            r.drive = drive_acc[31:0];
        end
        r.speed = spd[16:0];
        r.position = pos_acc;
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_TARGET_CIRCLES: circles_q = val[7:0];
            REG_TARGET_SPEED:   spd_lim_q = val[7:0];
            REG_POS_KP:         gain_pkp = val;
            REG_POS_KI:         gain_pki = val;
            REG_POS_KD:         gain_pkd = val;
            REG_VEL_KP:         gain_vkp = val;
            REG_VEL_KI:         gain_vki = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (tick_queue.size() != 0 || ctl_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_count();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4) return 16'($urandom_range(0, 200));
        if (p < 7) return 16'hffff - 16'($urandom_range(0, 200));
        return 16'($urandom());
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // driver
    int drv_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            drv_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                ctl_expected.push_back(control_tick(tick_queue.pop_front()));
                drv_gap = gap_len();
            end
            if (drv_gap > 0) drv_gap--;
            if (tick_queue.size() != 0 && drv_gap == 0 && !i_cfg_wr_en) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, tick_queue[0].run, tick_queue[0].raw_count};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (ctl_expected.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    t_ctl_out e;
                    e = ctl_expected.pop_front();
                    if (m_axis_tdata[31:0] !== e.drive) begin
                        $display("%0t: drive exp %0d got %0d", $time, e.drive,
                                 $signed(m_axis_tdata[31:0]));
                        errors++;
                    end
                    if (m_axis_tdata[48:32] !== e.speed) begin
                        $display("%0t: speed exp %0d got %0d", $time, e.speed,
                                 $signed(m_axis_tdata[48:32]));
                        errors++;
                    end
                    if (m_axis_tdata[80:49] !== e.position) begin
                        $display("%0t: position exp %0d got %0d", $time, e.position,
                                 $signed(m_axis_tdata[80:49]));
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (gap_len() == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        logic [15:0] dir_counts[8];
        errors = 0;
        cycles = 0;
        hold_off = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        m_axis_tready = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        circles_q = TARGET_CIRCLES_RST;
        spd_lim_q = TARGET_SPEED_RST;
        {gain_pkp, gain_pki, gain_pkd, gain_vkp, gain_vki} = '0;
        pos_acc = 0;
        {prev_perr, integ, prev_verr, drive_acc} = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, boundary counts, run off and on
        dir_counts = '{16'h0000, 16'hffff, 16'hefff, 16'hf000, 16'h0001, 16'hfffe,
                       16'h7fff, 16'h8000};
        foreach (dir_counts[k]) tick_queue.push_back('{dir_counts[k], 1'b0});
        foreach (dir_counts[k]) tick_queue.push_back('{dir_counts[k], 1'b1});
        wait_idle();

        // gains at the extremes: drive saturates, integral clamps
        write_reg(REG_TARGET_CIRCLES, 16'hff);
        write_reg(REG_TARGET_SPEED, 16'hff);
        write_reg(REG_POS_KP, 16'h7fff);
        write_reg(REG_POS_KI, 16'h8000);
        write_reg(REG_POS_KD, 16'h7fff);
        write_reg(REG_VEL_KP, 16'h7fff);
        write_reg(REG_VEL_KI, 16'h7fff);
        write_reg(3'd7, 16'h1234);
        for (int k = 0; k < 8; k++) tick_queue.push_back('{16'hf000, 1'b1});
        tick_queue.push_back('{16'h0000, 1'b0});
        wait_idle();

        // position moved far from target while stopped, then run with zero targets
        for (int k = 0; k < 6; k++) tick_queue.push_back('{16'hefff, 1'b0});
        wait_idle();
        write_reg(REG_TARGET_CIRCLES, 16'h0);
        write_reg(REG_TARGET_SPEED, 16'h0);
        write_reg(REG_POS_KP, 16'h8000);
        write_reg(REG_VEL_KI, 16'h8000);
        write_reg(REG_VEL_KP, 16'h8000);
        tick_queue.push_back('{16'h0000, 1'b1});
        tick_queue.push_back('{16'hffff, 1'b1});
        wait_idle();

        // random phases with various settings, receiver holds off in one
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_TARGET_CIRCLES, 16'($urandom_range(0, 255)));
            write_reg(REG_TARGET_SPEED, 16'($urandom_range(0, 255)));
            write_reg(REG_POS_KP, (ph == 5) ? 16'h0 : 16'($urandom()));
            write_reg(REG_POS_KI, 16'($urandom()));
            write_reg(REG_POS_KD, 16'($urandom()));
            write_reg(REG_VEL_KP,
                      (ph % 2) ? 16'($urandom_range(0, 2048)) : 16'($urandom()));
            write_reg(REG_VEL_KI,
                      (ph % 2) ? 16'($urandom_range(0, 1024)) : 16'($urandom()));
            if (ph == 2) hold_off = 600;
            for (int k = 0; k < 105; k++)
                tick_queue.push_back('{rand_count(), ($urandom_range(0, 9) != 0)});
            wait_idle();
        end
        stim_done = 1;
        repeat (40) @(posedge i_clk);
        if (errors == 0 && ctl_expected.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
